/* rtl/pof_pkg.sv */
// Shared types and constants of the port owner flow table.
package pof_pkg;

  localparam int PORT_BITS_DEF = 16;

  localparam int FPORT_W = 16;
  localparam int IP_W    = 32;
  localparam int PID_W   = 31;
  localparam int TIME_W  = 32;
  localparam int CFG_W   = 16;
  localparam int AGED_W  = 17;
  localparam int CIDX_W  = 2;

  localparam logic [CFG_W-1:0] DEF_SECONDS = 16'd30;

  localparam logic OP_SOCKET = 1'b0;
  localparam logic OP_PACKET = 1'b1;

  typedef enum logic [CIDX_W-1:0] {
    CFG_ENABLE   = 2'd0,
    CFG_TIMEOUT  = 2'd1,
    CFG_INTERVAL = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_REFRESHED = 3'd1,
    ST_MATCHED   = 3'd2,
    ST_MISS      = 3'd3,
    ST_EVICTED   = 3'd4,
    ST_IGNORED   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SWEEP,
    S_READ,
    S_RESOLVE
  } state_t;

  typedef struct packed {
    logic              vld;
    logic [FPORT_W-1:0] fport;
    logic [IP_W-1:0]   fip;
    logic [PID_W-1:0]  pid;
    logic [TIME_W-1:0] tstamp;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic clear;
    logic sweep;
    logic rd_item;
    logic resolve;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic sweep_due;
    logic clr_done;
    logic sweep_done;
    logic out_free;
  } sts_t;

endpackage

/* rtl/pof_in_if.sv */
// Input channel: one socket or packet event per transaction.
interface pof_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] host_port;
  logic [15:0] peer_port;
  logic [31:0] peer_addr;
  logic [30:0] owner_pid;
  logic [31:0] event_time;

  modport source (output valid, operation, host_port, peer_port, peer_addr,
                  owner_pid, event_time, input ready);
  modport sink   (input valid, operation, host_port, peer_port, peer_addr,
                  owner_pid, event_time, output ready);
endinterface

/* rtl/pof_out_if.sv */
// Result channel: one status record per transaction.
interface pof_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [30:0] matched_pid;
  logic [16:0] aged_out;

  modport source (output valid, status, matched_pid, aged_out, input ready);
  modport sink   (input valid, status, matched_pid, aged_out, output ready);
endinterface

/* rtl/pof_dpath.sv */
// Datapath: config registers, entry memory, sweep walker, resolve logic, output register.
module pof_dpath #(
  parameter int PORT_BITS = pof_pkg::PORT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [pof_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [pof_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                         in_operation,
  input  logic [15:0]                  in_host_port,
  input  logic [15:0]                  in_peer_port,
  input  logic [31:0]                  in_peer_addr,
  input  logic [30:0]                  in_owner_pid,
  input  logic [31:0]                  in_event_time,
  input  logic                         out_ready,
  output logic                         out_valid,
  output pof_pkg::status_t             out_status,
  output logic [30:0]                  out_matched_pid,
  output logic [16:0]                  out_aged_out,
  input  pof_pkg::cmd_t                cmd,
  output pof_pkg::sts_t                sts
);

  localparam int N = 1 << PORT_BITS;
  localparam logic [PORT_BITS:0] CNT_LAST = (PORT_BITS+1)'(N - 1);

  // configuration
  logic                       enable_r;
  logic [pof_pkg::CFG_W-1:0]  timeout_r;
  logic [pof_pkg::CFG_W-1:0]  interval_r;
  logic [pof_pkg::TIME_W-1:0] last_sweep_r;

  // latched item
  logic                        op_r;
  logic                        ign_r;
  logic [PORT_BITS-1:0]        idx_r;
  logic [pof_pkg::FPORT_W-1:0] fport_r;
  logic [pof_pkg::IP_W-1:0]    fip_r;
  logic [pof_pkg::PID_W-1:0]   pid_r;
  logic [pof_pkg::TIME_W-1:0]  now_r;

  // table
  pof_pkg::entry_t mem [N];
  pof_pkg::entry_t rd_data_r;
  logic [PORT_BITS-1:0] rd_addr;
  logic                 wr_en;
  logic [PORT_BITS-1:0] wr_addr;
  pof_pkg::entry_t      wr_data;

  // walker for clear and sweep
  logic [PORT_BITS:0]   cnt_r, cnt_nxt;
  logic                 sw_pend_r, sw_pend_nxt;
  logic [PORT_BITS-1:0] sw_addr_r, sw_addr_nxt;
  logic [pof_pkg::AGED_W-1:0] aged_r;

  logic [pof_pkg::TIME_W:0] sweep_at;
  logic [pof_pkg::TIME_W:0] age_lim;
  logic                     drop;
  pof_pkg::entry_t          drop_entry;

  pof_pkg::status_t           res_status;
  logic [pof_pkg::PID_W-1:0]  res_pid;
  logic                       res_we;
  pof_pkg::entry_t            res_entry;

  logic                       out_valid_r;
  pof_pkg::status_t           out_status_r;
  logic [pof_pkg::PID_W-1:0]  out_pid_r;
  logic [pof_pkg::AGED_W-1:0] out_aged_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b0;
      timeout_r  <= pof_pkg::DEF_SECONDS;
      interval_r <= pof_pkg::DEF_SECONDS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pof_pkg::CFG_ENABLE:   enable_r   <= cfg_wdata[0];
        pof_pkg::CFG_TIMEOUT:  timeout_r  <= cfg_wdata;
        pof_pkg::CFG_INTERVAL: interval_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sweep test, widened so the sum cannot wrap
  assign sweep_at = {1'b0, last_sweep_r} + (pof_pkg::TIME_W+1)'(interval_r);
  assign sts.sweep_due = enable_r && (in_operation == pof_pkg::OP_SOCKET) &&
                         (sweep_at <= {1'b0, in_event_time});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_sweep_r <= '0;
    end else if (cmd.accept && sts.sweep_due) begin
      last_sweep_r <= in_event_time;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r    <= in_operation;
      ign_r   <= !enable_r;
      idx_r   <= in_host_port[PORT_BITS-1:0];
      fport_r <= in_peer_port;
      fip_r   <= in_peer_addr;
      pid_r   <= in_owner_pid;
      now_r   <= in_event_time;
    end
  end

  // walker
  always_comb begin
    cnt_nxt     = cnt_r;
    sw_pend_nxt = 1'b0;
    sw_addr_nxt = sw_addr_r;
    if (cmd.accept) begin
      cnt_nxt = '0;
    end else if (cmd.clear) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (cmd.sweep && !cnt_r[PORT_BITS]) begin
      cnt_nxt     = cnt_r + 1'b1;
      sw_pend_nxt = 1'b1;
      sw_addr_nxt = cnt_r[PORT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      sw_pend_r <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      sw_pend_r <= sw_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sw_addr_r <= sw_addr_nxt;
  end

  assign sts.clr_done   = (cnt_r == CNT_LAST);
  assign sts.sweep_done = cnt_r[PORT_BITS] && !sw_pend_r;

  // aging test on the entry read in the previous cycle
  assign age_lim = {1'b0, rd_data_r.tstamp} + (pof_pkg::TIME_W+1)'(timeout_r);
  assign drop    = cmd.sweep && sw_pend_r && rd_data_r.vld && ({1'b0, now_r} >= age_lim);

  always_comb begin
    drop_entry     = rd_data_r;
    drop_entry.vld = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      aged_r <= '0;
    end else if (drop) begin
      aged_r <= aged_r + 1'b1;
    end
  end

  // per-item decision
  always_comb begin
    res_status = pof_pkg::ST_IGNORED;
    res_pid    = '0;
    res_we     = 1'b0;
    res_entry  = rd_data_r;
    if (ign_r) begin
      res_status = pof_pkg::ST_IGNORED;
    end else if (op_r == pof_pkg::OP_SOCKET) begin
      res_we = 1'b1;
      if (rd_data_r.vld && rd_data_r.fport == fport_r && rd_data_r.fip == fip_r) begin
        res_entry.tstamp = now_r;
        res_status       = pof_pkg::ST_REFRESHED;
      end else begin
        res_entry.vld    = 1'b1;
        res_entry.fport  = fport_r;
        res_entry.fip    = fip_r;
        res_entry.pid    = pid_r;
        res_entry.tstamp = now_r;
        res_status       = pof_pkg::ST_INSERTED;
      end
    end else begin
      if (!rd_data_r.vld) begin
        res_status = pof_pkg::ST_MISS;
      end else if (rd_data_r.fport != fport_r) begin
        res_entry.vld = 1'b0;
        res_we        = 1'b1;
        res_status    = pof_pkg::ST_EVICTED;
      end else begin
        res_pid    = rd_data_r.pid;
        res_status = pof_pkg::ST_MATCHED;
      end
    end
  end

  // memory port muxes
  always_comb begin
    priority if (cmd.sweep) begin
      rd_addr = cnt_r[PORT_BITS-1:0];
    end else if (cmd.rd_item) begin
      rd_addr = idx_r;
    end else begin
      rd_addr = in_host_port[PORT_BITS-1:0];
    end
  end

  always_comb begin
    priority if (cmd.clear) begin
      wr_en   = 1'b1;
      wr_addr = cnt_r[PORT_BITS-1:0];
      wr_data = '0;
    end else if (drop) begin
      wr_en   = 1'b1;
      wr_addr = sw_addr_r;
      wr_data = drop_entry;
    end else begin
      wr_en   = cmd.resolve && res_we;
      wr_addr = idx_r;
      wr_data = res_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.resolve) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resolve) begin
      out_status_r <= res_status;
      out_pid_r    <= res_pid;
      out_aged_r   <= aged_r;
    end
  end

  assign sts.out_free    = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_matched_pid = out_pid_r;
  assign out_aged_out    = out_aged_r;

endmodule

/* rtl/pof_ctrl.sv */
// Controller: sequences clearing, accept, sweep, table read and resolve.
module pof_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  pof_pkg::sts_t    sts,
  output pof_pkg::cmd_t    cmd
);

  pof_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pof_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      pof_pkg::S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_done) begin
          state_nxt = pof_pkg::S_IDLE;
        end
      end
      pof_pkg::S_IDLE: begin
        in_ready = sts.out_free;
        if (in_valid && sts.out_free) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.sweep_due ? pof_pkg::S_SWEEP : pof_pkg::S_RESOLVE;
        end
      end
      pof_pkg::S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_done) begin
          state_nxt = pof_pkg::S_READ;
        end
      end
      pof_pkg::S_READ: begin
        // re-read the item's entry after the sweep has finished with it
        cmd.rd_item = 1'b1;
        state_nxt   = pof_pkg::S_RESOLVE;
      end
      pof_pkg::S_RESOLVE: begin
        cmd.resolve = 1'b1;
        state_nxt   = pof_pkg::S_IDLE;
      end
      default: begin
        state_nxt = pof_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/port_owner_flow_table_top.sv */
// Top level of the port owner flow table.
//
//  channel | dir | transaction
//  --------+-----+---------------------------------------------------------
//  in_ch   | in  | operation, host_port, peer_port, peer_addr, pid, time
//  out_ch  | out | status, matched_pid, aged_out
//  cfg_*   | in  | write enable, register index, 16-bit data
//
// An item is read from the table at accept; decision and write-back follow in the resolve state.
// A socket event that triggers an aging sweep adds a sweep and a re-read of the item's entry; the
// sweep walks the entry table one entry per cycle.
// After reset a clearing pass over all 2^PORT_BITS entries runs before the first accept.
// While a result waits on out_ch.ready, in_ch is held off.
module port_owner_flow_table_top #(
  parameter int PORT_BITS = pof_pkg::PORT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  pof_in_if.sink                     in_ch,
  pof_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [pof_pkg::CIDX_W-1:0] cfg_index,
  input  logic [pof_pkg::CFG_W-1:0]  cfg_wdata
);

  pof_pkg::cmd_t    cmd_s;
  pof_pkg::sts_t    sts_s;
  logic             ready_s;
  pof_pkg::status_t status_s;

  pof_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (ready_s),
    .sts      (sts_s),
    .cmd      (cmd_s)
  );

  pof_dpath #(
    .PORT_BITS (PORT_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_operation    (in_ch.operation),
    .in_host_port    (in_ch.host_port),
    .in_peer_port    (in_ch.peer_port),
    .in_peer_addr    (in_ch.peer_addr),
    .in_owner_pid    (in_ch.owner_pid),
    .in_event_time   (in_ch.event_time),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_status      (status_s),
    .out_matched_pid (out_ch.matched_pid),
    .out_aged_out    (out_ch.aged_out),
    .cmd             (cmd_s),
    .sts             (sts_s)
  );

  assign in_ch.ready   = ready_s;
  assign out_ch.status = status_s;

  // one item in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("accept while an item is in flight");

  // each resolve presents a result
  a_resolve_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_s.resolve |=> out_ch.valid)
    else $error("resolve did not load the output register");

  // a result appears only from a resolve
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(cmd_s.resolve))
    else $error("result without resolve");

  // pid is reported only on a match
  a_pid_on_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && status_s != pof_pkg::ST_MATCHED) |-> (out_ch.matched_pid == '0))
    else $error("pid reported without match");

endmodule

/* verif/port_owner_flow_table_top_tb.sv */
// Self-checking testbench of the port owner flow table: directed and random event traffic.
module port_owner_flow_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Full-size table: every local port has an entry of its own.
  localparam int TB_PORT_BITS = pof_pkg::PORT_BITS_DEF;
  localparam int TBL_SIZE     = 1 << TB_PORT_BITS;
  localparam int SETTLE_CYC   = 8;
  localparam int MAX_CYCLES   = 30_000_000;
  localparam int MAX_PRINTS   = 40;

  localparam logic [pof_pkg::FPORT_W-1:0] FPORT_POOL [4] =
    '{16'd80, 16'd443, 16'd53, 16'hFFFF};
  localparam logic [pof_pkg::IP_W-1:0]    IP_POOL    [3] =
    '{32'h0A00_0001, 32'hC0A8_0001, 32'hFFFF_FFFF};

  typedef struct {
    logic                        op;
    logic [15:0]                 lport;
    logic [pof_pkg::FPORT_W-1:0] fport;
    logic [pof_pkg::IP_W-1:0]    fip;
    logic [pof_pkg::PID_W-1:0]   pid;
    logic [pof_pkg::TIME_W-1:0]  tsec;
  } owner_ev_t;

  typedef struct {
    pof_pkg::status_t           st;
    logic [pof_pkg::PID_W-1:0]  pid;
    logic [pof_pkg::AGED_W-1:0] aged;
  } owner_reply_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [pof_pkg::CIDX_W-1:0] cfg_index;
  logic [pof_pkg::CFG_W-1:0]  cfg_wdata;

  pof_in_if  in_ch ();
  pof_out_if out_ch ();

  port_owner_flow_table_top #(
    .PORT_BITS (TB_PORT_BITS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow of the table and registers
  logic                        own_vld   [TBL_SIZE];
  logic [pof_pkg::FPORT_W-1:0] own_fport [TBL_SIZE];
  logic [pof_pkg::IP_W-1:0]    own_fip   [TBL_SIZE];
  logic [pof_pkg::PID_W-1:0]   own_pid   [TBL_SIZE];
  logic [pof_pkg::TIME_W-1:0]  own_time  [TBL_SIZE];
  logic [pof_pkg::TIME_W-1:0]  last_sweep_s;
  logic                        cfg_en_m;
  logic [pof_pkg::CFG_W-1:0]   timeout_m;
  logic [pof_pkg::CFG_W-1:0]   interval_m;

  owner_reply_t due_replies[$];

  int unsigned err_cnt;
  int unsigned items_sent;
  int unsigned replies_checked;
  int unsigned sweeps_run;
  int unsigned aged_total;
  int unsigned status_tally [6];
  int unsigned burst_left;
  int unsigned cycle_cnt = 0;
  int unsigned rx_tick = 0;
  logic [pof_pkg::TIME_W-1:0] now_s;

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    if (err_cnt < MAX_PRINTS)
      $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    err_cnt++;
  endtask

  task automatic predict_owner_reply(input owner_ev_t ev);
    owner_reply_t r;
    logic [TB_PORT_BITS-1:0] slot;
    logic [32:0] sweep_at;
    logic [32:0] expiry;
    int i;
    slot   = ev.lport[TB_PORT_BITS-1:0];
    r.st   = pof_pkg::ST_IGNORED;
    r.pid  = '0;
    r.aged = '0;
    if (!cfg_en_m) begin
      r.st = pof_pkg::ST_IGNORED;
    end else if (ev.op == pof_pkg::OP_SOCKET) begin
      // widened so last sweep + interval cannot wrap
      sweep_at = {1'b0, last_sweep_s} + {17'b0, interval_m};
      if (sweep_at <= {1'b0, ev.tsec}) begin
        last_sweep_s = ev.tsec;
        sweeps_run++;
        for (i = 0; i < TBL_SIZE; i++) begin
          expiry = {1'b0, own_time[i]} + {17'b0, timeout_m};
          if (own_vld[i] && ({1'b0, ev.tsec} >= expiry)) begin
            own_vld[i] = 1'b0;
            r.aged     = r.aged + 1'b1;
          end
        end
      end
      if (own_vld[slot] && own_fport[slot] == ev.fport && own_fip[slot] == ev.fip) begin
        own_time[slot] = ev.tsec;
        r.st = pof_pkg::ST_REFRESHED;
      end else begin
        own_vld[slot]   = 1'b1;
        own_fport[slot] = ev.fport;
        own_fip[slot]   = ev.fip;
        own_pid[slot]   = ev.pid;
        own_time[slot]  = ev.tsec;
        r.st = pof_pkg::ST_INSERTED;
      end
    end else begin
      if (!own_vld[slot]) begin
        r.st = pof_pkg::ST_MISS;
      end else if (own_fport[slot] != ev.fport) begin
        own_vld[slot] = 1'b0;
        r.st = pof_pkg::ST_EVICTED;
      end else begin
        r.pid = own_pid[slot];
        r.st  = pof_pkg::ST_MATCHED;
      end
    end
    aged_total += r.aged;
    due_replies.push_back(r);
  endtask

  // Bursts of random length with random gaps; a zero gap chains bursts.
  task automatic pace();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_event(input owner_ev_t ev);
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= ev.op;
    in_ch.host_port  <= ev.lport;
    in_ch.peer_port  <= ev.fport;
    in_ch.peer_addr  <= ev.fip;
    in_ch.owner_pid  <= ev.pid;
    in_ch.event_time <= ev.tsec;
    do @(posedge clk); while (!in_ch.ready);
    predict_owner_reply(ev);
    items_sent++;
    pace();
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (due_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic cfg_write(input pof_pkg::cfg_idx_t idx,
                           input logic [pof_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    case (idx)
      pof_pkg::CFG_ENABLE:   cfg_en_m   = val[0];
      pof_pkg::CFG_TIMEOUT:  timeout_m  = val;
      pof_pkg::CFG_INTERVAL: interval_m = val;
      default: ;
    endcase
  endtask

  function automatic owner_ev_t mk_event(input logic op, input logic [15:0] lport,
                                         input logic [pof_pkg::FPORT_W-1:0] fport,
                                         input logic [pof_pkg::IP_W-1:0] fip,
                                         input logic [pof_pkg::PID_W-1:0] pid,
                                         input logic [pof_pkg::TIME_W-1:0] tsec);
    owner_ev_t ev;
    ev.op    = op;
    ev.lport = lport;
    ev.fport = fport;
    ev.fip   = fip;
    ev.pid   = pid;
    ev.tsec  = tsec;
    return ev;
  endfunction

  // Mostly a small set of busy ports with pooled peers, so that inserts are
  // followed by refreshes, matches and evictions; some fully random noise.
  function automatic owner_ev_t random_event();
    owner_ev_t ev;
    logic [TB_PORT_BITS-1:0] slot;
    slot = ($urandom_range(0, 7) == 0) ? TB_PORT_BITS'($urandom)
                                       : TB_PORT_BITS'($urandom_range(0, 15));
    ev.lport = 16'($urandom);
    ev.lport[TB_PORT_BITS-1:0] = slot;
    ev.op    = ($urandom_range(0, 1) == 1) ? pof_pkg::OP_PACKET : pof_pkg::OP_SOCKET;
    ev.fport = ($urandom_range(0, 5) == 0) ? 16'($urandom) : FPORT_POOL[$urandom_range(0, 3)];
    ev.fip   = ($urandom_range(0, 4) == 0) ? 32'($urandom) : IP_POOL[$urandom_range(0, 2)];
    ev.pid   = 31'($urandom);
    if (ev.op == pof_pkg::OP_SOCKET) begin
      now_s += $urandom_range(0, 6);
      if ($urandom_range(0, 39) == 0) now_s += $urandom_range(20, 120);
      // occasional stale timestamp, up to 20 behind now_s, which can be older than entries already stored
      ev.tsec = ($urandom_range(0, 9) == 0) ? now_s - $urandom_range(0, 20) : now_s;
    end else begin
      ev.tsec = 32'($urandom);
      if (own_vld[slot] && $urandom_range(0, 9) < 7) ev.fport = own_fport[slot];
    end
    return ev;
  endfunction

  task automatic test_disabled();
    send_event(mk_event(pof_pkg::OP_SOCKET, 16'h0001, 16'd80, 32'h0A00_0001, 31'd7, 32'd50));
    send_event(mk_event(pof_pkg::OP_PACKET, 16'h0001, 16'd80, 32'h0A00_0001, 31'd7, 32'd51));
    wait_idle();
    // only bit 0 of the enable register counts
    cfg_write(pof_pkg::CFG_ENABLE, 16'hFFFE);
    send_event(mk_event(pof_pkg::OP_SOCKET, 16'h0002, 16'd81, 32'h0A00_0002, 31'd8, 32'd52));
  endtask

  task automatic test_table_ops();
    wait_idle();
    cfg_write(pof_pkg::CFG_ENABLE, 16'h0001);
    // reset timeout and interval still in force
    send_event(mk_event(pof_pkg::OP_SOCKET, 16'h0010, 16'd80, 32'hC0A8_0101,
                        31'h0123_4567, 32'd100));
    send_event(mk_event(pof_pkg::OP_SOCKET, 16'h0010, 16'd80, 32'hC0A8_0101,
                        31'h0000_0009, 32'd101));
    send_event(mk_event(pof_pkg::OP_PACKET, 16'h0010, 16'd80, 32'h0, 31'h0, 32'd102));
    // same low byte, different port: a separate entry
    send_event(mk_event(pof_pkg::OP_PACKET, 16'hAB10, 16'd80, 32'h0, 31'h0, 32'd102));
    send_event(mk_event(pof_pkg::OP_PACKET, 16'h0010, 16'd81, 32'h0, 31'h0, 32'd103));
    send_event(mk_event(pof_pkg::OP_PACKET, 16'h0010, 16'd80, 32'h0, 31'h0, 32'd103));
    send_event(mk_event(pof_pkg::OP_SOCKET, 16'h0020, 16'hFFFF, 32'hFFFF_FFFF,
                        31'h7FFF_FFFF, 32'd102));
    send_event(mk_event(pof_pkg::OP_SOCKET, 16'h0020, 16'hFFFF, 32'h0, 31'h1, 32'd104));
    send_event(mk_event(pof_pkg::OP_SOCKET, 16'h0020, 16'h0, 32'h0, 31'h0, 32'd105));
    send_event(mk_event(pof_pkg::OP_PACKET, 16'h0020, 16'h0, 32'h0, 31'h0, 32'd105));
    send_event(mk_event(pof_pkg::OP_SOCKET, 16'hFFFF, 16'h1234, 32'h0A0B_0C0D,
                        31'h2AAA_AAAA, 32'd110));
    // packets never sweep, even with a far future timestamp
    send_event(mk_event(pof_pkg::OP_PACKET, 16'hFFFF, 16'h1234, 32'hFFFF_FFFF,
                        31'h7FFF_FFFF, 32'hFFFF_FFFF));
    send_event(mk_event(pof_pkg::OP_SOCKET, 16'h0005, 16'd22, 32'h0101_0101, 31'd5, 32'd131));
    send_event(mk_event(pof_pkg::OP_SOCKET, 16'h0006, 16'd22, 32'h0101_0101, 31'd6, 32'd200));
  endtask

  task automatic test_config_extremes();
    wait_idle();
    // zero timeout: anything not newer than the event ages out
    cfg_write(pof_pkg::CFG_TIMEOUT, 16'd0);
    cfg_write(pof_pkg::CFG_INTERVAL, 16'd0);
    send_event(mk_event(pof_pkg::OP_SOCKET, 16'h0007, 16'd443, 32'h0202_0202, 31'd70, 32'd300));
    send_event(mk_event(pof_pkg::OP_SOCKET, 16'h0008, 16'd443, 32'h0202_0202, 31'd80, 32'd300));
    send_event(mk_event(pof_pkg::OP_SOCKET, 16'h0009, 16'd443, 32'h0202_0202, 31'd90, 32'd299));
    send_event(mk_event(pof_pkg::OP_SOCKET, 16'h000A, 16'd443, 32'h0202_0202, 31'd100,
                        32'd300));
    wait_idle();
    cfg_write(pof_pkg::CFG_TIMEOUT, 16'hFFFF);
    cfg_write(pof_pkg::CFG_INTERVAL, 16'hFFFF);
    send_event(mk_event(pof_pkg::OP_SOCKET, 16'h000B, 16'd53, 32'h0303_0303, 31'd110, 32'd400));
    send_event(mk_event(pof_pkg::OP_SOCKET, 16'h000C, 16'd53, 32'h0303_0303, 31'd120,
                        32'd65835));
    wait_idle();
    cfg_write(pof_pkg::CFG_TIMEOUT, 16'd1);
    cfg_write(pof_pkg::CFG_INTERVAL, 16'd0);
    send_event(mk_event(pof_pkg::OP_SOCKET, 16'h000D, 16'd53, 32'h0303_0303, 31'd130,
                        32'd65900));
  endtask

  task automatic run_phase(input logic en, input logic [pof_pkg::CFG_W-1:0] tmo,
                           input logic [pof_pkg::CFG_W-1:0] ivl, input int unsigned n);
    int unsigned k;
    wait_idle();
    cfg_write(pof_pkg::CFG_ENABLE, {15'($urandom), en});
    cfg_write(pof_pkg::CFG_TIMEOUT, tmo);
    cfg_write(pof_pkg::CFG_INTERVAL, ivl);
    for (k = 0; k < n; k++) begin
      // hold off once mid-phase until the pipe is empty
      if (k == n / 2) wait_idle();
      send_event(random_event());
    end
  endtask

  // Each sweep walks the whole table, so sweep-heavy phases are kept short.
  task automatic test_random_traffic();
    now_s = 32'd70000;
    run_phase(1'b1, 16'd20, 16'd60, 300);
    run_phase(1'b1, 16'd6, 16'd0, 40);      // sweep on every socket event not older than the last sweep
    run_phase(1'b0, 16'd30, 16'd30, 60);
    run_phase(1'b1, 16'hFFFF, 16'hFFFF, 250);
    run_phase(1'b1, 16'd1, 16'd90, 250);
    run_phase(1'b1, 16'd40, 16'd120, 320);
  endtask

  // Timestamps at the top of the range: sums must not wrap.
  task automatic test_time_extremes();
    wait_idle();
    cfg_write(pof_pkg::CFG_ENABLE, 16'h0001);
    cfg_write(pof_pkg::CFG_TIMEOUT, 16'hFFFF);
    cfg_write(pof_pkg::CFG_INTERVAL, 16'hFFFF);
    send_event(mk_event(pof_pkg::OP_SOCKET, 16'h0030, 16'd80, 32'h0A00_0001, 31'd300,
                        32'hFFFF_FFF0));
    send_event(mk_event(pof_pkg::OP_SOCKET, 16'h0031, 16'd80, 32'h0A00_0001, 31'd301,
                        32'hFFFF_FFFF));
    wait_idle();
    cfg_write(pof_pkg::CFG_INTERVAL, 16'd0);
    send_event(mk_event(pof_pkg::OP_SOCKET, 16'h0032, 16'd80, 32'h0A00_0001, 31'd302,
                        32'hFFFF_FFFF));
    wait_idle();
    cfg_write(pof_pkg::CFG_TIMEOUT, 16'd15);
    send_event(mk_event(pof_pkg::OP_SOCKET, 16'h0033, 16'd80, 32'h0A00_0001, 31'd303,
                        32'hFFFF_FFFF));
  endtask

  // Result side: stall pattern steps through four modes selected by rx_tick[9:8]
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    case (rx_tick[9:8])
      2'd0:    out_ch.ready <= 1'b1;
      2'd1:    out_ch.ready <= 1'($urandom);
      2'd2:    out_ch.ready <= (rx_tick[2:0] == 3'd0);
      default: out_ch.ready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  always @(posedge clk) begin : reply_check
    owner_reply_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (due_replies.size() == 0) begin
        report_mismatch("transaction with nothing outstanding", 32'h0, 32'(out_ch.status));
      end else begin
        want = due_replies.pop_front();
        if (out_ch.status !== want.st)
          report_mismatch("status", 32'(want.st), 32'(out_ch.status));
        if (out_ch.matched_pid !== want.pid)
          report_mismatch("matched_pid", 32'(want.pid), 32'(out_ch.matched_pid));
        if (out_ch.aged_out !== want.aged)
          report_mismatch("aged_out", 32'(want.aged), 32'(out_ch.aged_out));
        status_tally[int'(want.st)]++;
        replies_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               due_replies.size());
      $display("port_owner_flow_table_top regression: fail");
      $finish;
    end
  end

  initial begin
    int i;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= pof_pkg::CFG_ENABLE;
    cfg_wdata        <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.operation  <= pof_pkg::OP_SOCKET;
    in_ch.host_port  <= '0;
    in_ch.peer_port  <= '0;
    in_ch.peer_addr  <= '0;
    in_ch.owner_pid  <= '0;
    in_ch.event_time <= '0;
    err_cnt = 0;
    items_sent = 0;
    replies_checked = 0;
    sweeps_run = 0;
    aged_total = 0;
    burst_left = 0;
    now_s = '0;
    for (i = 0; i < 6; i++) status_tally[i] = 0;
    for (i = 0; i < TBL_SIZE; i++) begin
      own_vld[i]   = 1'b0;
      own_fport[i] = '0;
      own_fip[i]   = '0;
      own_pid[i]   = '0;
      own_time[i]  = '0;
    end
    last_sweep_s = '0;
    cfg_en_m     = 1'b0;
    timeout_m    = pof_pkg::DEF_SECONDS;
    interval_m   = pof_pkg::DEF_SECONDS;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_disabled();
    test_table_ops();
    test_config_extremes();
    test_random_traffic();
    test_time_extremes();
    wait_idle();

    $display("checked %0d of %0d transactions: inserted %0d, refreshed %0d, matched %0d,",
             replies_checked, items_sent, status_tally[0], status_tally[1], status_tally[2]);
    $display("miss %0d, evicted %0d, ignored %0d; %0d sweeps aged out %0d entries",
             status_tally[3], status_tally[4], status_tally[5], sweeps_run, aged_total);
    if (err_cnt == 0 && due_replies.size() == 0) begin
      $display("port_owner_flow_table_top regression: pass");
    end else begin
      $display("port_owner_flow_table_top regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/pof_pkg.sv
rtl/pof_in_if.sv
rtl/pof_out_if.sv
rtl/pof_dpath.sv
rtl/pof_ctrl.sv
rtl/port_owner_flow_table_top.sv
verif/port_owner_flow_table_top_tb.sv
